>>> rtl/core/mce_pkg.sv
// Shared types, codes and the Morse code table for the character encoder.
package mce_pkg;

    localparam int MCE_CODE_W  = 16;
    localparam int CHAR_W      = 8;
    localparam int ROM_ADDR_W  = 7;
    localparam int SYMBOL_W    = 2;
    localparam int TDATA_W     = 8;

    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

    localparam logic [SYMBOL_W-1:0] SYM_DOT  = 2'd0;
    localparam logic [SYMBOL_W-1:0] SYM_DASH = 2'd1;
    localparam logic [SYMBOL_W-1:0] SYM_GAP  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT,
        ST_GAP
    } mce_state_t;

    // request handed from the input side to the emitter
    typedef struct packed {
        logic valid;
        logic is_space;
        logic is_lookup;
    } mce_req_t;

    // right-aligned codes, leading 1 marker, then 1 = dot, 0 = dash
    function automatic logic [MCE_CODE_W-1:0] rom_code(input logic [ROM_ADDR_W-1:0] addr);
        logic [MCE_CODE_W-1:0] code;
        unique case (addr)
            7'h61: code = 16'h0006; // a
            7'h62: code = 16'h0017;
            7'h63: code = 16'h0015;
            7'h64: code = 16'h000B;
            7'h65: code = 16'h0003;
            7'h66: code = 16'h001D;
            7'h67: code = 16'h0009;
            7'h68: code = 16'h001F;
            7'h69: code = 16'h0007;
            7'h6A: code = 16'h0018;
            7'h6B: code = 16'h000A;
            7'h6C: code = 16'h001B;
            7'h6D: code = 16'h0004;
            7'h6E: code = 16'h0005;
            7'h6F: code = 16'h0008;
            7'h70: code = 16'h0019;
            7'h71: code = 16'h0012;
            7'h72: code = 16'h000D;
            7'h73: code = 16'h000F;
            7'h74: code = 16'h0002;
            7'h75: code = 16'h000E;
            7'h76: code = 16'h001E;
            7'h77: code = 16'h000C;
            7'h78: code = 16'h0016;
            7'h79: code = 16'h0014;
            7'h7A: code = 16'h0013; // z
            7'h31: code = 16'h0030; // 1
            7'h32: code = 16'h0038;
            7'h33: code = 16'h003C;
            7'h34: code = 16'h003E;
            7'h35: code = 16'h003F;
            7'h36: code = 16'h002F;
            7'h37: code = 16'h0027;
            7'h38: code = 16'h0023;
            7'h39: code = 16'h0021; // 9
            7'h30: code = 16'h0020; // 0
            7'h2E: code = 16'h006A; // .
            7'h3F: code = 16'h0073; // ?
            7'h21: code = 16'h0054; // !
            7'h28: code = 16'h0029; // (
            7'h29: code = 16'h0052; // )
            7'h3A: code = 16'h0047; // :
            7'h3D: code = 16'h002E; // =
            7'h2D: code = 16'h005E; // -
            7'h22: code = 16'h006D; // "
            7'h2C: code = 16'h004C; // ,
            7'h27: code = 16'h0061; // '
            7'h2F: code = 16'h002D; // /
            7'h3B: code = 16'h0055; // ;
            7'h5F: code = 16'h0072; // _
            7'h40: code = 16'h0065; // @
            default: code = '0;
        endcase
        return code;
    endfunction

endpackage

>>> rtl/core/mce_rom.sv
// Synchronous code ROM, one read port, registered read data.
module mce_rom
    import mce_pkg::*;
#(
    parameter int CODE_WIDTH = MCE_CODE_W
)
(
    input  logic                  clk,
    input  logic                  rd_en,
    input  logic [ROM_ADDR_W-1:0] rd_addr,
    output logic [CODE_WIDTH-1:0] rd_data
);

    logic [MCE_CODE_W-1:0] full_code;
    logic [CODE_WIDTH-1:0] rd_data_reg;

    assign full_code = rom_code(rd_addr);

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= full_code[CODE_WIDTH-1:0];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/mce_emitter.sv
// Finds the start marker in a looked-up code and serialises its elements.
module mce_emitter
    import mce_pkg::*;
#(
    parameter int CODE_WIDTH = MCE_CODE_W
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  mce_req_t              req,
    output logic                  ready,
    input  logic [CODE_WIDTH-1:0] code,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SYMBOL_W-1:0]   out_symbol,
    output logic                  out_last
);

    localparam int CNT_W = $clog2(CODE_WIDTH);

    mce_state_t           state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SYMBOL_W-1:0]  symbol_reg, symbol_next;
    logic                 last_reg, last_next;

    logic [CNT_W-1:0]     top;
    logic                 top_found;
    logic                 out_free;
    logic [CNT_W-1:0]     elem_idx;
    logic                 load_elem;
    logic                 load_gap;

    // highest set bit of the code is the start marker
    always_comb
    begin
        top       = '0;
        top_found = 1'b0;
        for (int b = 0; b < CODE_WIDTH; b++)
        begin
            if (code[b])
            begin
                top       = CNT_W'(b);
                top_found = 1'b1;
            end
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign elem_idx = count_reg - CNT_W'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid && req.is_space)
                    state_next = ST_GAP;
                else if (req.valid && req.is_lookup)
                    state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                if (top_found && (top != '0))
                    state_next = ST_EMIT;
                else
                    state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (out_free && (count_reg == CNT_W'(1)))
                    state_next = ST_IDLE;
            end
            ST_GAP:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        ready     = 1'b0;
        load_elem = 1'b0;
        load_gap  = 1'b0;
        unique case (state_reg)
            ST_IDLE:   ready     = 1'b1;
            ST_LOOKUP: ;
            ST_EMIT:   load_elem = out_free;
            ST_GAP:    load_gap  = out_free;
            default: ;
        endcase
    end

    // the ROM data register holds until the next accepted lookup request,
    // so the code is read straight from it while emitting
    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        symbol_next    = symbol_reg;
        last_next      = last_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (state_reg == ST_LOOKUP)
            count_next = top;
        if (load_elem)
        begin
            out_valid_next = 1'b1;
            symbol_next    = code[elem_idx] ? SYM_DOT : SYM_DASH;
            last_next      = (count_reg == CNT_W'(1));
            count_next     = elem_idx;
        end
        else if (load_gap)
        begin
            out_valid_next = 1'b1;
            symbol_next    = SYM_GAP;
            last_next      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg  <= count_next;
        symbol_reg <= symbol_next;
        last_reg   <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_symbol = symbol_reg;
    assign out_last   = last_reg;

endmodule

>>> rtl/core/morse_character_encoder.sv
// Top level of the Morse character encoder.
// Each accepted character is folded to lower case and looked up in a code ROM with
// one registered read port; while the output stream is not stalled its Morse elements
// then leave one per cycle (symbol 0 dot, 1 dash, 2 word gap), tlast on the final one.
// A space gives one word gap, a character without a code gives nothing. A character
// passes through a ROM read, a marker search and then the serialiser, which sends
// one element a cycle; a stalled output stream holds it back. The next character is
// taken once the last element sits in the output register.
module morse_character_encoder
    import mce_pkg::*;
#(
    parameter int CODE_WIDTH = MCE_CODE_W
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [CHAR_W-1:0]  s_tdata,   // [7:0] character
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [1:0] symbol, [7:2] zero
    output logic               m_tlast
);

    logic                  accept;
    logic [CHAR_W-1:0]     folded;
    mce_req_t              req;
    logic [CODE_WIDTH-1:0] code;
    logic [SYMBOL_W-1:0]   symbol;

    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        if ((s_tdata >= CHAR_UPPER_A) && (s_tdata <= CHAR_UPPER_Z))
            folded = s_tdata + CASE_OFFSET;
        else
            folded = s_tdata;
    end

    assign req.valid     = accept;
    assign req.is_space  = (s_tdata == CHAR_SPACE);
    assign req.is_lookup = !s_tdata[CHAR_W-1] && (s_tdata != CHAR_SPACE);

    mce_rom #(
        .CODE_WIDTH (CODE_WIDTH)
    ) u_rom (
        .clk     (clk),
        .rd_en   (accept && req.is_lookup),
        .rd_addr (folded[ROM_ADDR_W-1:0]),
        .rd_data (code)
    );

    mce_emitter #(
        .CODE_WIDTH (CODE_WIDTH)
    ) u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .ready      (s_tready),
        .code       (code),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_symbol (symbol),
        .out_last   (m_tlast)
    );

    assign m_tdata = {{(TDATA_W-SYMBOL_W){1'b0}}, symbol};

endmodule
